// ===== design/bsws_pkg.sv =====
// Shared types and constants for the bounded stack with search.
// No dependencies; compiled first.
package bsws_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W = 3;
	localparam int WORD_W = 32;
	localparam int POS_W = 5;
	localparam int CNT_W = 5;
	localparam int SUM_W = 36;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_READ    = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_SUMMARY = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RDWAIT,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		status_t                    status;
		logic signed [WORD_W-1:0]   word_out;
		logic [POS_W-1:0]           match_position;
		logic [CNT_W-1:0]           entry_count;
		logic signed [SUM_W-1:0]    sum_out;
		logic signed [WORD_W-1:0]   min_out;
		logic signed [WORD_W-1:0]   max_out;
		logic                       last;
	} rsp_t;

endpackage

// ===== design/bsws_req_if.sv =====
// Request channel: one operation per beat.
// Depends on bsws_pkg for field widths.
interface bsws_req_if;
	import bsws_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [WORD_W-1:0] data_value;
	logic [POS_W-1:0]         position;

	modport source(output valid, opcode, data_value, position, input ready);
	modport sink(input valid, opcode, data_value, position, output ready);
endinterface

// ===== design/bsws_rsp_if.sv =====
// Response channel: one result per beat.
// Depends on bsws_pkg for field widths.
interface bsws_rsp_if;
	import bsws_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic signed [WORD_W-1:0] word_out;
	logic [POS_W-1:0]         match_position;
	logic [CNT_W-1:0]         entry_count;
	logic signed [SUM_W-1:0]  sum_out;
	logic signed [WORD_W-1:0] min_out;
	logic signed [WORD_W-1:0] max_out;
	logic                     last;

	modport source(output valid, status, word_out, match_position, entry_count,
		sum_out, min_out, max_out, last, input ready);
	modport sink(input valid, status, word_out, match_position, entry_count,
		sum_out, min_out, max_out, last, output ready);
endinterface

// ===== design/bsws_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/bounded_stack_with_search.sv =====
// Top level of the bounded stack with search and summary.
// Depends on bsws_pkg, bsws_req_if, bsws_rsp_if and bsws_ram.
//
// Usage:
//   req carries one operation per beat (opcode, data_value, position);
//   rsp returns results, each with last set on the final one of a request.
//   Push, pop, read and summary give one result; search gives one result per
//   matching position, walking from the top of the stack down, or a single
//   not-found result. Unused opcodes are dropped without a result.
// Timing:
//   One request is handled at a time. For push and the error cases the result
//   is registered from the decode state; pop and read first wait on a RAM read.
//   Search and summary stream the stored words through the RAM read port,
//   one word per cycle while no held result stalls a search walk.
//   req.ready is high only in the idle state between requests.
// Reset:
//   arst_n clears the entry count, the state, the walk flags and the output
//   valid; the RAM is not cleared, as no word is read before it is written.
// Backpressure:
//   One output register holds a result; the next request is accepted while
//   it waits. A stall on rsp freezes a search walk at a further match until taken.
module bounded_stack_with_search #(
	parameter int DEPTH = bsws_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bsws_req_if.sink   req,
	bsws_rsp_if.source rsp
);
	import bsws_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam int DW = DATA_WIDTH;

	state_t state_q, state_d;
	op_t op_q;
	logic [DW-1:0] key_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic rv_s1;
	logic [CW-1:0] rpos_s1;
	logic pend_q;
	logic [CW-1:0] pend_pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [DW-1:0] min_q, max_q;

	logic ov_q;
	rsp_t o_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] rdata;

	logic full, empty, bad_pos, match, stall, out_free, walk_done;
	logic [XW-1:0] pos_x, cnt_x;
	logic emit_v;
	rsp_t e;

	bsws_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(cnt_q);
	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign bad_pos = (pos_q == '0) || (pos_x > cnt_x);
	assign out_free = !ov_q || rsp.ready;
	assign match = rv_s1 && (op_q == OP_SEARCH) && (rdata == key_q);
	assign stall = match && pend_q && !out_free;
	assign walk_done = (idx_q == '0) && !rv_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (op_q)
					OP_PUSH: begin
						if (out_free) state_d = S_IDLE;
					end
					OP_POP: begin
						if (!empty) state_d = S_RDWAIT;
						else if (out_free) state_d = S_IDLE;
					end
					OP_READ: begin
						if (!bad_pos) state_d = S_RDWAIT;
						else if (out_free) state_d = S_IDLE;
					end
					OP_SEARCH: begin
						state_d = S_WALK;
					end
					OP_SUMMARY: begin
						if (!empty) state_d = S_WALK;
						else if (out_free) state_d = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_RDWAIT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_WALK: begin
				if (walk_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		emit_v = 1'b0;
		e = '0;
		e.status = STS_OK;
		e.entry_count = CNT_W'(cnt_q);
		e.last = 1'b1;
		ram_we = 1'b0;
		ram_waddr = AW'(cnt_q);
		ram_re = 1'b0;
		ram_raddr = AW'(idx_q - 1'b1);
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_DECODE: begin
				case (op_q)
					OP_PUSH: begin
						emit_v = 1'b1;
						if (full) begin
							e.status = STS_FULL;
						end else begin
							e.entry_count = CNT_W'(cnt_q + 1'b1);
							ram_we = out_free;
						end
					end
					OP_POP: begin
						if (empty) begin
							emit_v = 1'b1;
							e.status = STS_EMPTY;
						end else begin
							ram_re = 1'b1;
							ram_raddr = AW'(cnt_q - 1'b1);
						end
					end
					OP_READ: begin
						if (bad_pos) begin
							emit_v = 1'b1;
							e.status = STS_BAD_POS;
						end else begin
							ram_re = 1'b1;
							ram_raddr = AW'(pos_x - 1'b1);
						end
					end
					OP_SUMMARY: begin
						if (empty) begin
							emit_v = 1'b1;
							e.status = STS_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			S_RDWAIT: begin
				emit_v = 1'b1;
				e.word_out = WORD_W'($signed(rdata));
			end
			S_WALK: begin
				emit_v = match && pend_q;
				e.match_position = POS_W'(pend_pos_q);
				e.last = 1'b0;
				ram_re = !stall && (idx_q != '0);
			end
			S_FINISH: begin
				emit_v = 1'b1;
				if (op_q == OP_SEARCH) begin
					if (pend_q) begin
						e.match_position = POS_W'(pend_pos_q);
					end else begin
						e.status = STS_NOT_FOUND;
					end
				end else begin
					e.sum_out = sum_q;
					e.min_out = WORD_W'($signed(min_q));
					e.max_out = WORD_W'($signed(max_q));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			pend_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECODE) begin
				rv_s1 <= 1'b0;
				pend_q <= 1'b0;
				if (op_q == OP_PUSH && !full && out_free) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (op_q == OP_POP && !empty) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (state_q == S_WALK && !stall) begin
				rv_s1 <= ram_re;
				if (match) begin
					pend_q <= 1'b1;
				end
			end
			if (emit_v && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= op_t'(req.opcode);
			key_q <= req.data_value[DW-1:0];
			pos_q <= req.position;
		end
		if (state_q == S_DECODE) begin
			idx_q <= cnt_q;
			sum_q <= '0;
			min_q <= {1'b0, {(DW - 1){1'b1}}};
			max_q <= {1'b1, {(DW - 1){1'b0}}};
		end
		if (state_q == S_WALK && !stall) begin
			if (ram_re) begin
				idx_q <= idx_q - 1'b1;
			end
			rpos_s1 <= idx_q;
			if (match) begin
				pend_pos_q <= rpos_s1;
			end
			if (rv_s1) begin
				sum_q <= sum_q + SUM_W'($signed(rdata));
				if ($signed(rdata) < $signed(min_q)) min_q <= rdata;
				if ($signed(rdata) > $signed(max_q)) max_q <= rdata;
			end
		end
		if (emit_v && out_free) begin
			o_q <= e;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.status = o_q.status;
	assign rsp.word_out = o_q.word_out;
	assign rsp.match_position = o_q.match_position;
	assign rsp.entry_count = o_q.entry_count;
	assign rsp.sum_out = o_q.sum_out;
	assign rsp.min_out = o_q.min_out;
	assign rsp.max_out = o_q.max_out;
	assign rsp.last = o_q.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)) ||
			(cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("entry count moved by more than one");

	a_write_push: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DECODE) && (op_q == OP_PUSH) && !full)
		else $error("RAM write outside a push");

	a_walk_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == S_WALK))
		else $error("walk read in flight outside the walk");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !rsp.ready) |=> ov_q && $stable(o_q))
		else $error("held result lost under stall");
endmodule

// ===== verif/tb_bounded_stack_with_search.sv =====
// Testbench for bounded_stack_with_search: a directed table, then random traffic in four
// backpressure phases, each result checked against a table row or an in-bench stack model.
// Depends on bsws_pkg, bsws_req_if, bsws_rsp_if and the RTL of the block.
module tb_bounded_stack_with_search;
	timeunit 1ns;
	timeprecision 1ps;
	import bsws_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam logic [WORD_W-1:0] W_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] W_NEG1 = 32'hffff_ffff;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] val;
		logic [POS_W-1:0]  pos;
		logic [4:0]        reps;
		logic              typed;
		status_t           sts;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
	} dir_row_t;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [WORD_W-1:0] val;
		logic [POS_W-1:0]         pos;
		bit                       typed;
		rsp_t                     want;
	} op_beat_t;

	localparam int N_DIR = 26;
	localparam dir_row_t DIR_TBL [N_DIR] = '{
		'{OP_POP,     32'd0,   5'd0,  5'd1,  1'b1, STS_EMPTY,     32'd0,   5'd0},
		'{OP_SUMMARY, 32'd0,   5'd0,  5'd1,  1'b1, STS_EMPTY,     32'd0,   5'd0},
		'{OP_SEARCH,  32'd0,   5'd0,  5'd1,  1'b1, STS_NOT_FOUND, 32'd0,   5'd0},
		'{OP_READ,    32'd0,   5'd1,  5'd1,  1'b1, STS_BAD_POS,   32'd0,   5'd0},
		'{OP_PUSH,    W_MAX,   5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd1},
		'{OP_PUSH,    W_MIN,   5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd2},
		'{OP_PUSH,    W_NEG1,  5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd3},
		'{OP_PUSH,    W_NEG1,  5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd4},
		'{OP_PUSH,    32'd0,   5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd5},
		'{OP_READ,    32'd0,   5'd0,  5'd1,  1'b1, STS_BAD_POS,   32'd0,   5'd5},
		'{OP_READ,    32'd0,   5'd6,  5'd1,  1'b1, STS_BAD_POS,   32'd0,   5'd5},
		'{OP_READ,    32'd0,   5'd1,  5'd1,  1'b1, STS_OK,        W_MAX,   5'd5},
		'{OP_READ,    32'd0,   5'd2,  5'd1,  1'b1, STS_OK,        W_MIN,   5'd5},
		'{OP_SEARCH,  W_NEG1,  5'd0,  5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_SUMMARY, 32'd0,   5'd0,  5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_SPARE5,  W_NEG1,  5'd31, 5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_SPARE6,  W_MIN,   5'd16, 5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_SPARE7,  W_MAX,   5'd1,  5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_POP,     32'd0,   5'd0,  5'd1,  1'b1, STS_OK,        32'd0,   5'd4},
		'{OP_PUSH,    32'h55,  5'd0,  5'd12, 1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_PUSH,    32'd0,   5'd0,  5'd1,  1'b1, STS_FULL,      32'd0,   5'd16},
		'{OP_SEARCH,  32'h55,  5'd0,  5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_SUMMARY, 32'd0,   5'd0,  5'd1,  1'b0, STS_OK,        32'd0,   5'd0},
		'{OP_READ,    32'd0,   5'd16, 5'd1,  1'b1, STS_OK,        32'h55,  5'd16},
		'{OP_READ,    32'd0,   5'd17, 5'd1,  1'b1, STS_BAD_POS,   32'd0,   5'd16},
		'{OP_POP,     32'd0,   5'd0,  5'd2,  1'b0, STS_OK,        32'd0,   5'd0}
	};

	logic clk;
	logic arst_n;

	bsws_req_if req_ch();
	bsws_rsp_if rsp_ch();

	bounded_stack_with_search i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	logic signed [WORD_W-1:0] stk_words [DEPTH];
	int stk_cnt;
	rsp_t step_rsp[$];
	rsp_t pending_rsp[$];
	op_beat_t op_backlog[$];

	int send_idle_pct;
	int recv_stall_pct;
	int n_fail;
	int n_ops;
	int n_results;
	int n_multi_hit;
	int n_full;
	int n_empty;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Advances the stack model by one operation; results land in step_rsp.
	function automatic void stack_apply(input logic [OP_W-1:0] op,
		input logic signed [WORD_W-1:0] val, input logic [POS_W-1:0] pos);
		rsp_t r;
		logic signed [SUM_W-1:0] acc;
		logic signed [WORD_W-1:0] lo;
		logic signed [WORD_W-1:0] hi;
		int n;
		step_rsp.delete();
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_PUSH: begin
				if (stk_cnt >= DEPTH) begin
					r.status = STS_FULL;
					n_full++;
				end else begin
					stk_words[stk_cnt] = val;
					stk_cnt++;
					r.status = STS_OK;
				end
				r.entry_count = CNT_W'(stk_cnt);
				step_rsp.push_back(r);
			end
			OP_POP: begin
				if (stk_cnt == 0) begin
					r.status = STS_EMPTY;
					n_empty++;
				end else begin
					stk_cnt--;
					r.status = STS_OK;
					r.word_out = stk_words[stk_cnt];
				end
				r.entry_count = CNT_W'(stk_cnt);
				step_rsp.push_back(r);
			end
			OP_READ: begin
				if (pos == 0 || int'(pos) > stk_cnt) begin
					r.status = STS_BAD_POS;
				end else begin
					r.status = STS_OK;
					r.word_out = stk_words[pos - 1];
				end
				r.entry_count = CNT_W'(stk_cnt);
				step_rsp.push_back(r);
			end
			OP_SEARCH: begin
				n = 0;
				for (int i = stk_cnt; i > 0; i--) begin
					if (stk_words[i - 1] == val) begin
						r = '0;
						r.status = STS_OK;
						r.match_position = POS_W'(i);
						r.entry_count = CNT_W'(stk_cnt);
						step_rsp.push_back(r);
						n++;
					end
				end
				if (n == 0) begin
					r = '0;
					r.status = STS_NOT_FOUND;
					r.entry_count = CNT_W'(stk_cnt);
					r.last = 1'b1;
					step_rsp.push_back(r);
				end else begin
					r = step_rsp[n - 1];
					r.last = 1'b1;
					step_rsp[n - 1] = r;
					if (n > 1)
						n_multi_hit++;
				end
			end
			OP_SUMMARY: begin
				if (stk_cnt == 0) begin
					r.status = STS_EMPTY;
					n_empty++;
				end else begin
					acc = '0;
					lo = stk_words[0];
					hi = stk_words[0];
					for (int i = 0; i < stk_cnt; i++) begin
						acc = acc + SUM_W'(stk_words[i]);
						if (stk_words[i] < lo)
							lo = stk_words[i];
						if (stk_words[i] > hi)
							hi = stk_words[i];
					end
					r.status = STS_OK;
					r.sum_out = acc;
					r.min_out = lo;
					r.max_out = hi;
				end
				r.entry_count = CNT_W'(stk_cnt);
				step_rsp.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_word();
		logic signed [WORD_W-1:0] pool [8];
		pool = '{32'sd0, 32'sd1, -32'sd1, W_MIN, W_MAX, 32'sd42, -32'sd42, 32'sd7};
		if ($urandom_range(9) < 6)
			return pool[$urandom_range(7)];
		return $urandom;
	endfunction

	// Random traffic drifting between filling and draining phases.
	task automatic queue_random(input int n);
		op_beat_t b;
		int done;
		int trend_left;
		bit filling;
		int roll;
		done = 0;
		trend_left = 0;
		filling = 1'b1;
		while (done < n) begin
			if (trend_left == 0) begin
				filling = ~filling;
				trend_left = $urandom_range(10, 30);
			end
			trend_left--;
			b = '{op: OP_PUSH, val: pick_word(), pos: '0, typed: 1'b0, want: '0};
			b.pos = ($urandom_range(9) < 7) ? POS_W'($urandom_range(17)) : POS_W'($urandom);
			roll = $urandom_range(99);
			if (roll < 5)
				b.op = OP_W'($urandom_range(5, 7));
			else if (roll < (filling ? 50 : 15))
				b.op = OP_PUSH;
			else if (roll < 60)
				b.op = OP_POP;
			else if (roll < 75)
				b.op = OP_READ;
			else if (roll < 90)
				b.op = OP_SEARCH;
			else
				b.op = OP_SUMMARY;
			if (!filling && roll >= 5 && roll < 15)
				b.op = OP_POP;
			if (filling && roll >= 50 && roll < 60 && $urandom_range(1))
				b.op = OP_PUSH;
			op_backlog.push_back(b);
			if (b.op <= OP_SUMMARY)
				done++;
		end
	endtask

	// Request side: present backlog beats, hold until taken, apply the model on accept.
	always @(posedge clk) begin
		bit took;
		op_beat_t b;
		took = req_ch.valid && req_ch.ready;
		if (took) begin
			b = op_backlog.pop_front();
			stack_apply(b.op, b.val, b.pos);
			if (b.typed)
				pending_rsp.push_back(b.want);
			else
				foreach (step_rsp[i])
					pending_rsp.push_back(step_rsp[i]);
			n_ops++;
		end
		if (req_ch.valid && !took) begin
		end else if (arst_n && op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			req_ch.valid <= 1'b1;
			req_ch.opcode <= op_backlog[0].op;
			req_ch.data_value <= op_backlog[0].val;
			req_ch.position <= op_backlog[0].pos;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// Result side: random stall, compare each beat with the oldest expectation.
	always @(posedge clk) begin
		rsp_t exp_r;
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result beat: status %0d", rsp_ch.status);
				n_fail++;
			end else begin
				exp_r = pending_rsp.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
					n_fail++;
				end
				if (rsp_ch.word_out !== exp_r.word_out) begin
					$error("word_out: expected %0d, got %0d", exp_r.word_out, rsp_ch.word_out);
					n_fail++;
				end
				if (rsp_ch.match_position !== exp_r.match_position) begin
					$error("match_position: expected %0d, got %0d",
						exp_r.match_position, rsp_ch.match_position);
					n_fail++;
				end
				if (rsp_ch.entry_count !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						exp_r.entry_count, rsp_ch.entry_count);
					n_fail++;
				end
				if (rsp_ch.sum_out !== exp_r.sum_out) begin
					$error("sum_out: expected %0d, got %0d", exp_r.sum_out, rsp_ch.sum_out);
					n_fail++;
				end
				if (rsp_ch.min_out !== exp_r.min_out) begin
					$error("min_out: expected %0d, got %0d", exp_r.min_out, rsp_ch.min_out);
					n_fail++;
				end
				if (rsp_ch.max_out !== exp_r.max_out) begin
					$error("max_out: expected %0d, got %0d", exp_r.max_out, rsp_ch.max_out);
					n_fail++;
				end
				if (rsp_ch.last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, rsp_ch.last);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		op_beat_t b;
		int send_pct [4];
		int stall_pct [4];
		send_pct = '{0, 85, 0, 37};
		stall_pct = '{0, 0, 85, 37};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.data_value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stk_cnt = 0;
		n_fail = 0;
		n_ops = 0;
		n_results = 0;
		n_multi_hit = 0;
		n_full = 0;
		n_empty = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			for (int k = 0; k < DIR_TBL[i].reps; k++) begin
				b.op = DIR_TBL[i].op;
				b.val = DIR_TBL[i].val;
				b.pos = DIR_TBL[i].pos;
				b.typed = DIR_TBL[i].typed;
				b.want = '0;
				b.want.status = DIR_TBL[i].sts;
				b.want.word_out = DIR_TBL[i].word;
				b.want.entry_count = DIR_TBL[i].cnt;
				b.want.last = 1'b1;
				op_backlog.push_back(b);
			end
		end
		while (op_backlog.size() != 0)
			@(posedge clk);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = stall_pct[p];
			queue_random(N_RANDOM / 4);
			while (op_backlog.size() != 0)
				@(posedge clk);
		end

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 24) @(posedge clk);

		$display("Ran %0d operations over four backpressure phases, %0d result beats checked.",
			n_ops, n_results);
		$display("Saw %0d multi-hit searches, %0d full pushes, %0d empty pops/summaries.",
			n_multi_hit, n_full, n_empty);
		if (n_fail == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== bounded_stack_with_search.f =====
design/bsws_pkg.sv
design/bsws_req_if.sv
design/bsws_rsp_if.sv
design/bsws_ram.sv
design/bounded_stack_with_search.sv
verif/tb_bounded_stack_with_search.sv
